FILE: rtl/tgc_pkg.sv
// Shared types, register map and event codes for the touch gesture classifier.
package tgc_pkg;

    typedef logic [3:0] event_kind_t;

    localparam event_kind_t EV_NONE   = 4'd0;
    localparam event_kind_t EV_DOWN   = 4'd1;
    localparam event_kind_t EV_MOVE   = 4'd2;
    localparam event_kind_t EV_LONG   = 4'd3;
    localparam event_kind_t EV_LEFT   = 4'd4;
    localparam event_kind_t EV_RIGHT  = 4'd5;
    localparam event_kind_t EV_SWUP   = 4'd6;
    localparam event_kind_t EV_SWDOWN = 4'd7;
    localparam event_kind_t EV_TAP    = 4'd8;
    localparam event_kind_t EV_UP     = 4'd9;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_SCREEN_WIDTH    = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_LONG_PRESS_MS   = 3'd2;
    localparam logic [2:0] REG_SWIPE_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_TAP_MAX_MS      = 3'd4;

    localparam logic [12:0] RST_SCREEN_WIDTH    = 13'd960;
    localparam logic [12:0] RST_SCREEN_HEIGHT   = 13'd540;
    localparam logic [15:0] RST_LONG_PRESS_MS   = 16'd800;
    localparam logic [11:0] RST_SWIPE_THRESHOLD = 12'd50;
    localparam logic [15:0] RST_TAP_MAX_MS      = 16'd400;

    // Status byte layout
    localparam int STATUS_VALID_BIT = 7;
    localparam logic [7:0] STATUS_COUNT_MASK = 8'h0F;

    typedef struct packed {
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [15:0] long_press_ms;
        logic [11:0] swipe_threshold;
        logic [15:0] tap_max_ms;
    } cfg_t;

    typedef struct packed {
        logic               read_ok;
        logic [7:0]         status_byte;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic [31:0]        now_ms;
    } poll_t;

endpackage

FILE: rtl/tgc_cfg.sv
// APB register file holding the classifier configuration.
module tgc_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tgc_pkg::cfg_t      cfg
);

    tgc_pkg::cfg_t cfg_reg;
    tgc_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[4:2])
                tgc_pkg::REG_SCREEN_WIDTH:    cfg_next.screen_width    = pwdata[12:0];
                tgc_pkg::REG_SCREEN_HEIGHT:   cfg_next.screen_height   = pwdata[12:0];
                tgc_pkg::REG_LONG_PRESS_MS:   cfg_next.long_press_ms   = pwdata[15:0];
                tgc_pkg::REG_SWIPE_THRESHOLD: cfg_next.swipe_threshold = pwdata[11:0];
                tgc_pkg::REG_TAP_MAX_MS:      cfg_next.tap_max_ms      = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width    <= tgc_pkg::RST_SCREEN_WIDTH;
            cfg_reg.screen_height   <= tgc_pkg::RST_SCREEN_HEIGHT;
            cfg_reg.long_press_ms   <= tgc_pkg::RST_LONG_PRESS_MS;
            cfg_reg.swipe_threshold <= tgc_pkg::RST_SWIPE_THRESHOLD;
            cfg_reg.tap_max_ms      <= tgc_pkg::RST_TAP_MAX_MS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            tgc_pkg::REG_SCREEN_WIDTH:    prdata = 32'(cfg_reg.screen_width);
            tgc_pkg::REG_SCREEN_HEIGHT:   prdata = 32'(cfg_reg.screen_height);
            tgc_pkg::REG_LONG_PRESS_MS:   prdata = 32'(cfg_reg.long_press_ms);
            tgc_pkg::REG_SWIPE_THRESHOLD: prdata = 32'(cfg_reg.swipe_threshold);
            tgc_pkg::REG_TAP_MAX_MS:      prdata = 32'(cfg_reg.tap_max_ms);
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/tgc_engine.sv
// Press tracking state and combinational event classification for one poll.
module tgc_engine #(
    parameter int COORD_WIDTH = 12,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  tgc_pkg::poll_t                poll,
    input  tgc_pkg::cfg_t                 cfg,
    output tgc_pkg::event_kind_t          kind,
    output logic [COORD_WIDTH-1:0]        pos_x,
    output logic [COORD_WIDTH-1:0]        pos_y,
    output logic signed [COORD_WIDTH:0]   delta_x,
    output logic signed [COORD_WIDTH:0]   delta_y
);

    localparam int CLW = (COORD_WIDTH > 13) ? COORD_WIDTH : 13;
    localparam int CMW = (CLW > 15) ? CLW : 15;
    localparam int MW  = (COORD_WIDTH > 12) ? COORD_WIDTH : 12;
    localparam logic [CLW-1:0] CMAX = CLW'((1 << COORD_WIDTH) - 1);

    logic                   was_down_reg, was_down_next;
    logic                   long_done_reg, long_done_next;
    logic [COORD_WIDTH-1:0] down_x_reg, down_x_next;
    logic [COORD_WIDTH-1:0] down_y_reg, down_y_next;
    logic [COORD_WIDTH-1:0] prev_x_reg, prev_x_next;
    logic [COORD_WIDTH-1:0] prev_y_reg, prev_y_next;
    logic [TIME_WIDTH-1:0]  down_time_reg, down_time_next;

    logic                   pressed;
    logic [COORD_WIDTH-1:0] cx, cy;
    logic [TIME_WIDTH-1:0]  now_t, elapsed;
    logic signed [COORD_WIDTH:0] mx, my, sx, sy;
    logic [COORD_WIDTH-1:0] mag_sx, mag_sy;
    logic                   over_th, long_hit, tap_ok;

    function automatic logic [COORD_WIDTH-1:0] clamp_coord(
        input logic signed [15:0] v,
        input logic [12:0]        size
    );
        logic [12:0]    hi13;
        logic [CLW-1:0] hi_c;
        logic [CMW-1:0] v_ext;
        logic [CMW-1:0] hi_ext;
        hi13   = (size == 13'd0) ? 13'd0 : size - 13'd1;
        hi_c   = (CLW'(hi13) > CMAX) ? CMAX : CLW'(hi13);
        v_ext  = CMW'(v[14:0]);
        hi_ext = CMW'(hi_c);
        if (v[15]) begin
            clamp_coord = '0;
        end else if (v_ext > hi_ext) begin
            clamp_coord = hi_c[COORD_WIDTH-1:0];
        end else begin
            clamp_coord = v[COORD_WIDTH-1:0];
        end
    endfunction

    function automatic logic [COORD_WIDTH-1:0] mag(input logic signed [COORD_WIDTH:0] d);
        logic [COORD_WIDTH:0] n;
        n   = -d;
        mag = d[COORD_WIDTH] ? n[COORD_WIDTH-1:0] : d[COORD_WIDTH-1:0];
    endfunction

    assign pressed = poll.status_byte[tgc_pkg::STATUS_VALID_BIT]
                  && ((poll.status_byte & tgc_pkg::STATUS_COUNT_MASK) != 8'd0);
    assign cx      = clamp_coord(poll.raw_x, cfg.screen_width);
    assign cy      = clamp_coord(poll.raw_y, cfg.screen_height);
    assign now_t   = poll.now_ms[TIME_WIDTH-1:0];
    assign elapsed = now_t - down_time_reg;

    assign mx = $signed({1'b0, cx}) - $signed({1'b0, prev_x_reg});
    assign my = $signed({1'b0, cy}) - $signed({1'b0, prev_y_reg});
    assign sx = $signed({1'b0, prev_x_reg}) - $signed({1'b0, down_x_reg});
    assign sy = $signed({1'b0, prev_y_reg}) - $signed({1'b0, down_y_reg});
    assign mag_sx = mag(sx);
    assign mag_sy = mag(sy);

    assign over_th  = (MW'(mag_sx) > MW'(cfg.swipe_threshold))
                   || (MW'(mag_sy) > MW'(cfg.swipe_threshold));
    assign long_hit = !long_done_reg && (elapsed > TIME_WIDTH'(cfg.long_press_ms));
    assign tap_ok   = (elapsed < TIME_WIDTH'(cfg.tap_max_ms)) && !long_done_reg;

    always_comb begin
        kind           = tgc_pkg::EV_NONE;
        pos_x          = '0;
        pos_y          = '0;
        delta_x        = '0;
        delta_y        = '0;
        was_down_next  = was_down_reg;
        long_done_next = long_done_reg;
        down_x_next    = down_x_reg;
        down_y_next    = down_y_reg;
        down_time_next = down_time_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;

        // A failed read gives none and leaves the state alone
        if (poll.read_ok) begin
            if (pressed && !was_down_reg) begin
                kind           = tgc_pkg::EV_DOWN;
                pos_x          = cx;
                pos_y          = cy;
                down_x_next    = cx;
                down_y_next    = cy;
                down_time_next = now_t;
                long_done_next = 1'b0;
            end else if (pressed) begin
                pos_x = cx;
                pos_y = cy;
                if (long_hit) begin
                    kind           = tgc_pkg::EV_LONG;
                    long_done_next = 1'b1;
                end else begin
                    kind    = tgc_pkg::EV_MOVE;
                    delta_x = mx;
                    delta_y = my;
                end
            end else if (was_down_reg) begin
                pos_x = prev_x_reg;
                pos_y = prev_y_reg;
                if (over_th) begin
                    // Ties go to the horizontal axis
                    if (mag_sx >= mag_sy) begin
                        kind = (!sx[COORD_WIDTH] && (sx != '0)) ? tgc_pkg::EV_RIGHT
                                                                : tgc_pkg::EV_LEFT;
                    end else begin
                        kind = (!sy[COORD_WIDTH] && (sy != '0)) ? tgc_pkg::EV_SWDOWN
                                                                : tgc_pkg::EV_SWUP;
                    end
                    delta_x = sx;
                    delta_y = sy;
                end else if (tap_ok) begin
                    kind = tgc_pkg::EV_TAP;
                end else begin
                    kind = tgc_pkg::EV_UP;
                end
            end
            if (pressed) begin
                prev_x_next = cx;
                prev_y_next = cy;
            end
            was_down_next = pressed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_down_reg  <= 1'b0;
            long_done_reg <= 1'b0;
            down_x_reg    <= '0;
            down_y_reg    <= '0;
            down_time_reg <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
        end else if (step) begin
            was_down_reg  <= was_down_next;
            long_done_reg <= long_done_next;
            down_x_reg    <= down_x_next;
            down_y_reg    <= down_y_next;
            down_time_reg <= down_time_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
        end
    end

endmodule

FILE: rtl/touch_gesture_classifier.sv
// Top level: poll input register, classification engine, event output register.
// An accepted poll reaches m_tvalid through the input register, then the result
// register; the result register loads only when the output is free.
// Throughput: one poll per cycle; the input register refills in the cycle it
// hands its item to the result register, so only a stalled m_tready slows it.
// Reset (aresetn low, synchronous): both valids and the press state clear,
// configuration registers return to their defaults.
module touch_gesture_classifier #(
    parameter int COORD_WIDTH = 12,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Poll channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [71:0]         s_tdata,   // status_byte, raw_x, raw_y, now_ms
    input  logic                s_tuser,   // read_ok
    // Event channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [((4*COORD_WIDTH+2+7)/8)*8-1:0] m_tdata, // pos_x, pos_y, delta_x, delta_y
    output logic [3:0]          m_tuser,   // event_kind
    // Configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int OUT_W = ((4*COORD_WIDTH+2+7)/8)*8;

    tgc_pkg::cfg_t  cfg;
    tgc_pkg::poll_t poll_reg;
    logic           in_valid_reg;
    logic           out_valid_reg;
    logic           advance;

    tgc_pkg::event_kind_t        kind;
    logic [COORD_WIDTH-1:0]      pos_x, pos_y;
    logic signed [COORD_WIDTH:0] delta_x, delta_y;

    tgc_pkg::event_kind_t        kind_reg;
    logic [COORD_WIDTH-1:0]      pos_x_reg, pos_y_reg;
    logic signed [COORD_WIDTH:0] delta_x_reg, delta_y_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    tgc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgc_engine #(
        .COORD_WIDTH (COORD_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .poll    (poll_reg),
        .cfg     (cfg),
        .kind    (kind),
        .pos_x   (pos_x),
        .pos_y   (pos_y),
        .delta_x (delta_x),
        .delta_y (delta_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: the poll loads on accept, the result on advance; both hold otherwise
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            poll_reg.read_ok     <= s_tuser;
            poll_reg.status_byte <= s_tdata[7:0];
            poll_reg.raw_x       <= s_tdata[23:8];
            poll_reg.raw_y       <= s_tdata[39:24];
            poll_reg.now_ms      <= s_tdata[71:40];
        end
        if (advance) begin
            kind_reg    <= kind;
            pos_x_reg   <= pos_x;
            pos_y_reg   <= pos_y;
            delta_x_reg <= delta_x;
            delta_y_reg <= delta_y;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = OUT_W'({delta_y_reg, delta_x_reg, pos_y_reg, pos_x_reg});

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("result register not loaded after advance");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending poll dropped");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= tgc_pkg::EV_UP))
        else $error("event kind out of range");

    a_no_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == tgc_pkg::EV_NONE || m_tuser == tgc_pkg::EV_DOWN
            || m_tuser == tgc_pkg::EV_LONG || m_tuser == tgc_pkg::EV_TAP
            || m_tuser == tgc_pkg::EV_UP))
        |-> (delta_x_reg == '0 && delta_y_reg == '0))
        else $error("nonzero delta on event without displacement");

    a_none_at_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == tgc_pkg::EV_NONE) |-> (pos_x_reg == '0 && pos_y_reg == '0))
        else $error("none event carries a position");

endmodule
